[rtl/srsi_pkg.sv]
// ----------------------------------------------------------------------------
// srsi_pkg: shared types and constants of the sparse row sorted insert block
// Sizes of the row store, the layout of one stored row and the status codes.
// ----------------------------------------------------------------------------
package srsi_pkg;

  localparam int MAX_ROWS   = 4096;
  localparam int ROW_SLOTS  = 16;
  localparam int VALUE_BITS = 32;

  localparam int COL_BITS      = 12;
  localparam int ROW_ADDR_BITS = $clog2(MAX_ROWS);
  // holds a count from zero up to ROW_SLOTS
  localparam int CNT_BITS      = $clog2(ROW_SLOTS + 1);
  // selects one slot of a row
  localparam int SLOT_SEL_BITS = (ROW_SLOTS > 1) ? $clog2(ROW_SLOTS) : 1;

  localparam logic [1:0] STATUS_UPDATED   = 2'd0;
  localparam logic [1:0] STATUS_INSERTED  = 2'd1;
  localparam logic [1:0] STATUS_ROW_FULL  = 2'd2;
  localparam logic [1:0] STATUS_OUT_RANGE = 2'd3;

  localparam logic REG_ROWS_IN_USE  = 1'b0;
  localparam logic REG_ROW_CAPACITY = 1'b1;

  typedef struct packed {
    logic [COL_BITS-1:0]   col;
    logic [VALUE_BITS-1:0] val;
  } slot_t;

  typedef slot_t [ROW_SLOTS-1:0] row_t;

  localparam int ROW_BITS = $bits(row_t);

endpackage

[rtl/srsi_ram.sv]
// ----------------------------------------------------------------------------
// srsi_ram: simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module srsi_ram #(
  parameter int DATA_BITS = 8,
  parameter int ADDR_BITS = 4
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/sparse_row_sorted_insert.sv]
// ----------------------------------------------------------------------------
// sparse_row_sorted_insert: sparse matrix row store with sorted insert
// Keeps each row's columns in ascending order with their values and sets one
// matrix element per request.
// ----------------------------------------------------------------------------
// A request (row, column, value) is taken when start is high and busy is low.
// The block reads the whole row as one wide word from the row RAM, then walks
// its slots with a single shared column comparator, one slot per cycle, until
// it reaches the lower-bound slot. In that cycle it either overwrites the value
// of a matching column, or shifts the later slots up by one and writes the new
// entry, and writes the row back; a full row with no matching column is
// left as it is. A request for a row out of range ends the search at once.
// busy drops in the cycle the result is shown, so a new request is taken
// only after the result of the last one. The result (done with status, slot,
// row_entries) stays for exactly one cycle and cannot be held off by the
// receiver. After reset the block clears the per-row entry counts, one row
// per cycle, and keeps busy high meanwhile; register writes are taken at
// all times.
// ----------------------------------------------------------------------------
module sparse_row_sorted_insert (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic [11:0] row,
  input  logic [11:0] column,
  input  logic [31:0] value,
  // result channel
  output logic        done,
  output logic [1:0]  status,
  output logic [4:0]  slot,
  output logic [4:0]  row_entries,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_SEARCH = 3'b100
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic [12:0] rows_in_use;
  logic [4:0]  row_capacity;

  // latched request
  logic [11:0]                  row_q;
  logic [srsi_pkg::COL_BITS-1:0] col_q;
  logic [srsi_pkg::VALUE_BITS-1:0] val_q;
  logic                         out_range_q;

  // sweep and search counters
  logic [srsi_pkg::ROW_ADDR_BITS-1:0] clr;
  logic [srsi_pkg::CNT_BITS-1:0]      idx, idx_next;

  // RAM ports
  logic                               cnt_we;
  logic [srsi_pkg::ROW_ADDR_BITS-1:0] cnt_waddr;
  logic [srsi_pkg::CNT_BITS-1:0]      cnt_wdata;
  logic [srsi_pkg::CNT_BITS-1:0]      cnt_rdata;
  logic                               row_we;
  logic [srsi_pkg::ROW_ADDR_BITS-1:0] raddr;
  logic [srsi_pkg::ROW_BITS-1:0]      row_rdata;
  srsi_pkg::row_t                     rd_row, wr_row;

  // search datapath
  logic [srsi_pkg::CNT_BITS-1:0] count;
  srsi_pkg::slot_t               cur, new_slot;
  logic                          in_cnt, col_lt, col_eq, hit, full, decide;

  logic       accept, cfg_wr;
  logic       done_next;
  logic [1:0] status_next;
  logic [4:0] slot_next, entries_next;

  assign accept = start && (state == ST_IDLE);
  assign busy   = (state != ST_IDLE);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use  <= 13'd4096;
      row_capacity <= 5'd16;
    end else if (cfg_wr) begin
      case (paddr[2])
        srsi_pkg::REG_ROWS_IN_USE:  rows_in_use  <= pwdata[12:0];
        srsi_pkg::REG_ROW_CAPACITY: row_capacity <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      srsi_pkg::REG_ROWS_IN_USE:  prdata = {19'd0, rows_in_use};
      srsi_pkg::REG_ROW_CAPACITY: prdata = {27'd0, row_capacity};
      default:                    prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------- memories
  // Present the incoming row while idle so its data is ready in the first
  // search cycle; hold the latched row afterwards.
  assign raddr = (state == ST_IDLE) ? srsi_pkg::ROW_ADDR_BITS'(row)
                                    : srsi_pkg::ROW_ADDR_BITS'(row_q);

  srsi_ram #(
    .DATA_BITS (srsi_pkg::CNT_BITS),
    .ADDR_BITS (srsi_pkg::ROW_ADDR_BITS)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (raddr),
    .rdata (cnt_rdata)
  );

  srsi_ram #(
    .DATA_BITS (srsi_pkg::ROW_BITS),
    .ADDR_BITS (srsi_pkg::ROW_ADDR_BITS)
  ) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (srsi_pkg::ROW_ADDR_BITS'(row_q)),
    .wdata (srsi_pkg::ROW_BITS'(wr_row)),
    .raddr (raddr),
    .rdata (row_rdata)
  );

  assign rd_row = srsi_pkg::row_t'(row_rdata);

  // ---------------------------------------------------------------- search
  // Saturate the stored count at the slot count of a row.
  assign count = (32'(cnt_rdata) > srsi_pkg::ROW_SLOTS)
               ? srsi_pkg::CNT_BITS'(srsi_pkg::ROW_SLOTS) : cnt_rdata;

  // The shared comparator: one stored column against the requested one.
  assign cur    = rd_row[idx[srsi_pkg::SLOT_SEL_BITS-1:0]];
  assign in_cnt = (idx < count);
  assign col_lt = in_cnt && (cur.col < col_q);
  assign col_eq = in_cnt && (cur.col == col_q);
  assign hit    = col_eq;
  // count never exceeds ROW_SLOTS, so this is count >= min(capacity, slots)
  assign full   = (32'(count) >= 32'(row_capacity)) ||
                  (32'(count) >= srsi_pkg::ROW_SLOTS);
  assign decide = (state == ST_SEARCH) && !out_range_q && !col_lt;

  assign new_slot.col = col_q;
  assign new_slot.val = val_q;

  // Row to write back: overwrite on a hit, otherwise open a gap at idx.
  always_comb begin
    for (int k = 0; k < srsi_pkg::ROW_SLOTS; k++) begin
      if (hit) begin
        wr_row[k] = (srsi_pkg::CNT_BITS'(k) == idx) ? new_slot : rd_row[k];
      end else if (srsi_pkg::CNT_BITS'(k) < idx) begin
        wr_row[k] = rd_row[k];
      end else if (srsi_pkg::CNT_BITS'(k) == idx) begin
        wr_row[k] = new_slot;
      end else if (k > 0) begin
        wr_row[k] = rd_row[k-1];
      end else begin
        wr_row[k] = new_slot;
      end
    end
  end

  assign row_we = decide && (hit || !full);

  always_comb begin
    if (state == ST_CLEAR) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr;
      cnt_wdata = '0;
    end else begin
      cnt_we    = decide && !hit && !full;
      cnt_waddr = srsi_pkg::ROW_ADDR_BITS'(row_q);
      cnt_wdata = count + srsi_pkg::CNT_BITS'(1);
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_next   = state;
    idx_next     = idx;
    done_next    = 1'b0;
    status_next  = srsi_pkg::STATUS_OUT_RANGE;
    slot_next    = 5'd0;
    entries_next = 5'd0;
    case (state)
      ST_CLEAR: begin
        if (32'(clr) == srsi_pkg::MAX_ROWS - 1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        idx_next = '0;
        if (accept) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (out_range_q) begin
          // drop the request, report an empty result
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else if (col_lt) begin
          // advance to the next slot
          idx_next = idx + srsi_pkg::CNT_BITS'(1);
        end else begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
          slot_next  = 5'(idx);
          if (hit) begin
            status_next  = srsi_pkg::STATUS_UPDATED;
            entries_next = 5'(count);
          end else if (full) begin
            status_next  = srsi_pkg::STATUS_ROW_FULL;
            entries_next = 5'(count);
          end else begin
            status_next  = srsi_pkg::STATUS_INSERTED;
            entries_next = 5'(count + srsi_pkg::CNT_BITS'(1));
          end
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr   <= '0;
      idx   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      done  <= done_next;
      if (state == ST_CLEAR) begin
        clr <= clr + srsi_pkg::ROW_ADDR_BITS'(1);
      end
    end
  end

  // hold the request and register the result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      row_q       <= row;
      col_q       <= column;
      val_q       <= srsi_pkg::VALUE_BITS'(value);
      out_range_q <= !(({1'b0, row} < rows_in_use) && (32'(row) < srsi_pkg::MAX_ROWS));
    end
    status      <= status_next;
    slot        <= slot_next;
    row_entries <= entries_next;
  end

endmodule
